>>> rtl/pheromone_grid_diffusion_macros.svh
// assertion macros for the pheromone grid diffusion block
// used by the checker; expects clk_i and rst_ni in scope
`ifndef PHEROMONE_GRID_DIFFUSION_MACROS_SVH
`define PHEROMONE_GRID_DIFFUSION_MACROS_SVH

// consequent checked at the edge of the antecedent
`define PGD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked at the edge after the antecedent
`define PGD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// consequent checked later than the antecedent, through |=> ##1
`define PGD_ASSERT_LATER(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> ##1 (cons)) \
    else $error(msg);

`endif

>>> rtl/pgd_pkg.sv
// types and constants of the pheromone grid diffusion block
// no dependencies; used by the top level and the checker
package pgd_pkg;

  // request codes
  typedef enum logic [1:0] {
    REQ_DEPOSIT = 2'd0,
    REQ_ERASE   = 2'd1,
    REQ_READ    = 2'd2,
    REQ_DIFFUSE = 2'd3
  } req_type_e;

  // control states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_KEEP_DIV,
    ST_KEEP_SET,
    ST_SWEEP,
    ST_DRAIN,
    ST_ACCESS
  } state_e;

  // level format, unsigned Q10.12
  localparam int unsigned LEVEL_W   = 22;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 22'd4096000;

  // evaporation rate register
  localparam int unsigned RATE_W = 16;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;
  localparam int unsigned STEP_W = 16;

  // keep factor: d = round(rate*dt / 1600) = floor(((p + 800) >> 6) / 25)
  localparam int unsigned P_W        = RATE_W + STEP_W;
  localparam int unsigned KEEP_ROUND = 800;
  localparam int unsigned KEEP_PRESH = 6;
  localparam int unsigned KX_W       = P_W + 1 - KEEP_PRESH;
  localparam int unsigned RECIP25_W  = 28;
  localparam logic [RECIP25_W-1:0] RECIP25 = 28'd171798692;
  localparam int unsigned RECIP25_SH = 32;
  localparam int unsigned KMUL_W     = KX_W + RECIP25_W;
  localparam int unsigned D_W        = KMUL_W - RECIP25_SH;
  localparam int unsigned K_W        = 17;
  localparam int unsigned KEEP_ONE   = 65536;

  // stencil: v = round(S * k / (5 * 65536)) = floor(((S*k + 163840) >> 16) / 5)
  localparam int unsigned SUM_W      = LEVEL_W + 3;
  localparam int unsigned PROD_W     = SUM_W + K_W;
  localparam int unsigned DIFF_ROUND = 163840;
  localparam int unsigned DIFF_PRESH = 16;
  localparam int unsigned Q_W        = 26;
  localparam int unsigned RECIP5_W   = 26;
  localparam logic [RECIP5_W-1:0] RECIP5 = 26'd53687092;
  localparam int unsigned RECIP5_SH  = 28;
  localparam int unsigned MUL5_W     = Q_W + RECIP5_W;
  localparam int unsigned VAL_W      = MUL5_W - RECIP5_SH;

  // one column of the 3x3 window: rows r-2, r-1, r
  typedef struct packed {
    logic [LEVEL_W-1:0] top;
    logic [LEVEL_W-1:0] mid;
    logic [LEVEL_W-1:0] bot;
  } col_t;

endpackage

>>> rtl/pgd_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module pgd_ram #(
  parameter int unsigned WIDTH = 22,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port; read data holds when not enabled
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pheromone_grid_diffusion.sv
// top level of the pheromone grid diffusion block
// depends on pgd_pkg and pgd_ram
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_valid_i / in_ready_o + fields      | item in
//   out     | out_valid_o / out_ready_i + level_o   | item out
//   cfg     | cfg_we_i + cfg_wdata_i                | register write
//
// deposit, erase and read: the accept cycle reads the grid ram, and ST_ACCESS then
// writes back a deposit or erase and loads the output register.
// diffuse: the sweep streams the grid ram one cell a cycle through two line
// buffers and a 5-stage stencil pipeline.
// after reset a clearing pass zeroes the grid ram.
// an output stall holds the block in its write-back cycle until the item is taken.
module pheromone_grid_diffusion
  import pgd_pkg::*;
#(
  parameter int unsigned GRID_W = 64,
  parameter int unsigned GRID_H = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RATE_W-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [5:0]         cell_x_i,
  input  logic [5:0]         cell_y_i,
  input  logic [LEVEL_W-1:0] amount_i,
  input  logic [STEP_W-1:0]  step_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [LEVEL_W-1:0] level_o
);

  localparam int unsigned CELLS = GRID_W * GRID_H;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned XW    = $clog2(GRID_W);
  localparam int unsigned YW    = $clog2(GRID_H);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
  localparam logic [XW-1:0] LAST_X    = XW'(GRID_W - 1);

  state_e state_q, state_d;

  logic [RATE_W-1:0]  rate_q;
  logic [AW-1:0]      ra_q, ra_d;
  logic [XW-1:0]      rx_q, rx_d;
  logic [YW-1:0]      ry_q, ry_d;

  // accepted item
  req_type_e          op_q;
  logic [AW-1:0]      op_addr_q;
  logic [LEVEL_W-1:0] amount_q;
  logic [P_W-1:0]     p_q;
  logic [KMUL_W-1:0]  kmul_q;
  logic [K_W-1:0]     k_q;

  // output register
  logic               out_valid_q;
  logic [LEVEL_W-1:0] level_q;

  // request address
  logic [XW-1:0]      req_x;
  logic [YW-1:0]      req_y;
  logic [AW-1:0]      req_addr;

  // grid ram ports
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [LEVEL_W-1:0] mem_wdata, mem_rdata;

  // line buffer ports
  logic [2*LEVEL_W-1:0] lb_wdata, lb_rdata;

  // control strobes
  logic               in_fire, out_free, acc_done, sweep_issue, pipe_busy;
  logic [LEVEL_W:0]   dep_sum;
  logic [LEVEL_W-1:0] acc_val;
  logic [P_W:0]       kx_sum;
  logic [KX_W-1:0]    kx;
  logic [D_W-1:0]     kd;

  // stencil pipeline
  logic               s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q;
  logic [XW-1:0]      s1_x_q, s2_x_q;
  logic [YW-1:0]      s1_r_q, s2_r_q;
  logic [AW-1:0]      s1_addr_q, s2_addr_q, s3_addr_q, s4_addr_q, s5_addr_q;
  col_t               win_q [3];
  logic [SUM_W-1:0]   st_sum;
  logic               interior;
  logic [SUM_W-1:0]   s3_sum_q;
  logic [PROD_W-1:0]  s4_prod_q;
  logic [PROD_W:0]    q_sum;
  logic [Q_W-1:0]     q_val;
  logic [MUL5_W-1:0]  s5_mul_q;
  logic [VAL_W-1:0]   s5_raw;
  logic [LEVEL_W-1:0] s5_val;

  // clamp the addressed cell to the grid
  always_comb begin
    if (int'(cell_x_i) > GRID_W - 1) begin
      req_x = LAST_X;
    end else begin
      req_x = XW'(cell_x_i);
    end
    if (int'(cell_y_i) > GRID_H - 1) begin
      req_y = YW'(GRID_H - 1);
    end else begin
      req_y = YW'(cell_y_i);
    end
    req_addr = AW'(req_y) * AW'(GRID_W) + AW'(req_x);
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign pipe_busy  = s1_vld_q || s2_vld_q || s3_vld_q || s4_vld_q || s5_vld_q;

  // single-cell result: saturating deposit, stored level for read, zero for erase and diffuse
  assign dep_sum = {1'b0, mem_rdata} + {1'b0, amount_q};
  always_comb begin
    case (op_q)
      REQ_DEPOSIT: acc_val = (dep_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX
                                                           : dep_sum[LEVEL_W-1:0];
      REQ_READ:    acc_val = mem_rdata;
      default:     acc_val = '0;
    endcase
  end

  // keep factor arithmetic
  assign kx_sum = {1'b0, p_q} + (P_W+1)'(KEEP_ROUND);
  assign kx     = kx_sum[KEEP_PRESH +: KX_W];
  assign kd     = kmul_q[RECIP25_SH +: D_W];

  // next state, sweep counters and ram control
  always_comb begin
    state_d     = state_q;
    ra_d        = ra_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    mem_re      = 1'b0;
    mem_raddr   = ra_q;
    mem_we      = 1'b0;
    mem_waddr   = ra_q;
    mem_wdata   = '0;
    acc_done    = 1'b0;
    sweep_issue = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (ra_q == LAST_ADDR) begin
          ra_d    = '0;
          state_d = ST_IDLE;
        end else begin
          ra_d = ra_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          mem_re    = 1'b1;
          mem_raddr = req_addr;
          state_d   = (req_type_i == REQ_DIFFUSE) ? ST_KEEP_DIV : ST_ACCESS;
        end
      end
      ST_KEEP_DIV: begin
        state_d = ST_KEEP_SET;
      end
      ST_KEEP_SET: begin
        ra_d    = '0;
        rx_d    = '0;
        ry_d    = '0;
        state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        mem_re      = 1'b1;
        sweep_issue = 1'b1;
        if (rx_q == LAST_X) begin
          rx_d = '0;
          ry_d = ry_q + YW'(1);
        end else begin
          rx_d = rx_q + XW'(1);
        end
        if (ra_q == LAST_ADDR) begin
          state_d = ST_DRAIN;
        end else begin
          ra_d = ra_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_d = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        if (out_free) begin
          acc_done = 1'b1;
          state_d  = ST_IDLE;
          if (op_q == REQ_DEPOSIT || op_q == REQ_ERASE) begin
            mem_we    = 1'b1;
            mem_waddr = op_addr_q;
            mem_wdata = acc_val;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // stencil write-back, only while the sweep pipeline runs
    if (s5_vld_q) begin
      mem_we    = 1'b1;
      mem_waddr = s5_addr_q;
      mem_wdata = s5_val;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ra_q        <= '0;
      rx_q        <= '0;
      ry_q        <= '0;
      rate_q      <= RATE_RESET;
      out_valid_q <= 1'b0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      s4_vld_q    <= 1'b0;
      s5_vld_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      ra_q     <= ra_d;
      rx_q     <= rx_d;
      ry_q     <= ry_d;
      s1_vld_q <= sweep_issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q && interior;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
      if (acc_done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item capture and keep factor
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q      <= req_type_e'(req_type_i);
      op_addr_q <= req_addr;
      amount_q  <= amount_i;
      p_q       <= rate_q * step_time_i;
    end
    if (state_q == ST_KEEP_DIV) begin
      kmul_q <= kx * RECIP25;
    end
    if (state_q == ST_KEEP_SET) begin
      k_q <= (kd >= D_W'(KEEP_ONE)) ? '0 : K_W'(KEEP_ONE - int'(kd));
    end
    if (acc_done) begin
      level_q <= acc_val;
    end
  end

  // grid ram
  pgd_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (CELLS)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // line buffers: old rows r-1 (upper half) and r-2 (lower half) per column
  assign lb_wdata = {mem_rdata, lb_rdata[2*LEVEL_W-1:LEVEL_W]};

  pgd_ram #(
    .WIDTH (2 * LEVEL_W),
    .DEPTH (GRID_W)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_vld_q),
    .waddr_i (s1_x_q),
    .wdata_i (lb_wdata),
    .re_i    (sweep_issue),
    .raddr_i (rx_q),
    .rdata_o (lb_rdata)
  );

  // stencil sum around the middle column of the window
  assign st_sum = SUM_W'(win_q[1].top) + SUM_W'(win_q[1].mid) + SUM_W'(win_q[1].bot)
                + SUM_W'(win_q[2].mid) + SUM_W'(win_q[0].mid);
  assign interior = (s2_x_q >= XW'(2)) && (s2_r_q >= YW'(2));

  // rounding and division by five
  assign q_sum  = {1'b0, s4_prod_q} + (PROD_W+1)'(DIFF_ROUND);
  assign q_val  = q_sum[DIFF_PRESH +: Q_W];
  assign s5_raw = s5_mul_q[RECIP5_SH +: VAL_W];
  assign s5_val = (s5_raw > VAL_W'(LEVEL_MAX)) ? LEVEL_MAX : s5_raw[LEVEL_W-1:0];

  // stencil pipeline payload
  always_ff @(posedge clk_i) begin
    if (sweep_issue) begin
      s1_x_q    <= rx_q;
      s1_r_q    <= ry_q;
      s1_addr_q <= ra_q;
    end
    if (s1_vld_q) begin
      win_q[0]  <= '{top: lb_rdata[LEVEL_W-1:0],
                     mid: lb_rdata[2*LEVEL_W-1:LEVEL_W],
                     bot: mem_rdata};
      win_q[1]  <= win_q[0];
      win_q[2]  <= win_q[1];
      s2_x_q    <= s1_x_q;
      s2_r_q    <= s1_r_q;
      s2_addr_q <= s1_addr_q;
    end
    s3_sum_q  <= st_sum;
    s3_addr_q <= s2_addr_q - AW'(GRID_W) - AW'(1);
    s4_prod_q <= s3_sum_q * k_q;
    s4_addr_q <= s3_addr_q;
    s5_mul_q  <= q_val * RECIP5;
    s5_addr_q <= s4_addr_q;
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;

endmodule

>>> rtl/pgd_checker.sv
// port-level checker for the pheromone grid diffusion block, with its bind
// depends on pgd_pkg and pheromone_grid_diffusion_macros.svh
`include "pheromone_grid_diffusion_macros.svh"

module pgd_checker
  import pgd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         req_type_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [LEVEL_W-1:0] level_o
);

  // a pending result stays until taken
  `PGD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "out item dropped")

  // levels never pass the saturation point
  `PGD_ASSERT_NOW(a_level_max, out_valid_o, level_o <= LEVEL_MAX, "level above maximum")

  // items are never accepted back to back
  `PGD_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "back-to-back accept")

  // a single-cell item with a free output shows its result after its ST_ACCESS state
  `PGD_ASSERT_LATER(a_cell_result,
    in_valid_i && in_ready_o && !out_valid_o && req_type_i != REQ_DIFFUSE,
    out_valid_o, "single-cell result late")

  // erase reports zero
  `PGD_ASSERT_LATER(a_erase_zero,
    in_valid_i && in_ready_o && !out_valid_o && req_type_i == REQ_ERASE,
    level_o == '0, "erase result not zero")

endmodule

bind pheromone_grid_diffusion pgd_checker u_pgd_checker (.*);
